[sv/prr_pkg.sv]
// Shared types, constants and a helper function for the polyphase rational resampler.
// Depends on nothing; every other file of the block but prr_chk uses it.
package prr_pkg;

  localparam int PHASES         = 5;
  localparam int TAPS_PER_PHASE = 257;
  localparam int COEF_DEPTH     = PHASES * TAPS_PER_PHASE;

  localparam int PHASE_W   = (PHASES > 1) ? $clog2(PHASES) : 1;
  localparam int HIST_AW   = (TAPS_PER_PHASE > 1) ? $clog2(TAPS_PER_PHASE) : 1;
  localparam int FILL_W    = $clog2(TAPS_PER_PHASE + 1);
  localparam int COEF_AW   = 11;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int DEC_W     = 8;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = 44;
  localparam int FRAC_BITS = 17;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [COEF_AW-1:0]         coef_idx_t;
  typedef logic [DEC_W-1:0]           dec_t;
  typedef logic [PHASE_W-1:0]         phase_t;
  typedef logic [HIST_AW-1:0]         hist_addr_t;
  typedef logic [FILL_W-1:0]          fill_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [ACC_W:0]      bias_t;
  typedef logic [APB_AW-1:0]          apb_addr_t;
  typedef logic [APB_DW-1:0]          apb_data_t;

  localparam hist_addr_t HIST_LAST   = hist_addr_t'(TAPS_PER_PHASE - 1);
  localparam fill_t      FILL_FULL   = fill_t'(TAPS_PER_PHASE);
  localparam coef_idx_t  COEF_STRIDE = coef_idx_t'(PHASES);
  localparam int         ROUND_HALF  = 1 << (FRAC_BITS - 1);
  localparam int         SAMPLE_MAX  = 32767;
  localparam int         SAMPLE_MIN  = -32768;

  // Register indexes, taken from paddr[2]
  localparam logic REG_DECIMATION  = 1'b0;
  localparam logic REG_PASSTHROUGH = 1'b1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic      command;
    sample_t   sample_in;
    coef_idx_t coef_index;
    coef_t     coef_value;
  } item_t;

  typedef struct packed {
    dec_t decimation;
    logic passthrough;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic issue;
    logic round;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mac_needed;
    logic pipe_busy;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    dec_t   counter;
    logic   fired;
    phase_t last;
  } phase_res_t;

  // Steps the decimation counter once per interpolation phase and
  // reports the last phase that fired.
  function automatic phase_res_t phase_step(dec_t cnt, dec_t dec);
    phase_res_t r;
    dec_t       c;
    c       = cnt;
    r.fired = 1'b0;
    r.last  = '0;
    for (int p = 0; p < PHASES; p++) begin
      c = c + dec_t'(1);
      if (c == dec) begin
        c       = '0;
        r.fired = 1'b1;
        r.last  = phase_t'(p);
      end
    end
    r.counter = c;
    return r;
  endfunction

endpackage

[sv/prr_if.sv]
// Valid/ready channel interfaces for the resampler's input and result streams.
// Depends on prr_pkg for the payload types.
interface prr_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  prr_pkg::sample_t   sample_in;
  prr_pkg::coef_idx_t coef_index;
  prr_pkg::coef_t     coef_value;

  modport source (output valid, command, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, command, sample_in, coef_index, coef_value, output ready);
endinterface

interface prr_out_if;
  logic             valid;
  logic             ready;
  prr_pkg::sample_t sample_out;
  logic             fresh;

  modport source (output valid, sample_out, fresh, input ready);
  modport sink   (input valid, sample_out, fresh, output ready);
endinterface

[sv/prr_cfg.sv]
// APB-style register block holding the decimation and passthrough settings.
// Depends on prr_pkg.
module prr_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  prr_pkg::apb_addr_t paddr,
  input  prr_pkg::apb_data_t pwdata,
  output prr_pkg::apb_data_t prdata,
  output logic               pready,
  output prr_pkg::cfg_t      cfg
);
  import prr_pkg::*;

  dec_t decimation_r;
  logic passthrough_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decimation_r  <= dec_t'(1);
      passthrough_r <= 1'b0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_DECIMATION:  decimation_r  <= pwdata[DEC_W-1:0];
        REG_PASSTHROUGH: passthrough_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DECIMATION:  prdata = apb_data_t'(decimation_r);
      REG_PASSTHROUGH: prdata = apb_data_t'(passthrough_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.decimation  = decimation_r;
  assign cfg.passthrough = passthrough_r;

endmodule

[sv/prr_ctrl.sv]
// Sequencing state machine: accepts an item, runs the tap loop and releases the result.
// Depends on prr_pkg.
module prr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prr_pkg::dp_stat_t   stat,
  output prr_pkg::ctrl_cmd_t  cmd
);
  import prr_pkg::*;

  state_t     state_r, state_nxt;
  hist_addr_t tap_r, tap_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        tap_nxt   = '0;
        state_nxt = stat.mac_needed ? ST_MAC : ST_RESULT;
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        if (tap_r == HIST_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          tap_nxt = tap_r + hist_addr_t'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/prr_dp.sv]
// Datapath: history and coefficient memories, phase counter, MAC pipeline and output register.
// Depends on prr_pkg.
module prr_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  prr_pkg::cfg_t       cfg,
  input  prr_pkg::item_t      item,
  input  prr_pkg::ctrl_cmd_t  cmd,
  output prr_pkg::dp_stat_t   stat,
  output logic                out_valid,
  input  logic                out_ready,
  output prr_pkg::sample_t    sample_out,
  output logic                fresh
);
  import prr_pkg::*;

  sample_t    hist_mem [TAPS_PER_PHASE];
  coef_t      coef_mem [COEF_DEPTH];

  item_t      item_r;
  hist_addr_t wr_ptr_r, wr_ptr_nxt;
  fill_t      fill_r, fill_nxt;
  dec_t       phase_cnt_r;
  sample_t    held_r;
  logic       fresh_r;
  hist_addr_t rd_ptr_r;
  coef_idx_t  coef_addr_r;
  fill_t      left_r;
  sample_t    hist_q_r;
  coef_t      coef_q_r;
  logic       ok1_r;
  logic       v1_r;
  logic       v2_r;
  prod_t      prod_r;
  acc_t       acc_r;
  logic       out_valid_r;
  sample_t    out_sample_r;
  logic       out_fresh_r;

  phase_res_t ph;
  logic       filter_item;
  prod_t      coef_ext;
  prod_t      hist_ext;
  bias_t      biased;
  bias_t      quot;
  sample_t    rounded;

  assign ph          = phase_step(phase_cnt_r, cfg.decimation);
  assign filter_item = (item_r.command == CMD_SAMPLE) && !cfg.passthrough;
  assign wr_ptr_nxt  = (wr_ptr_r == HIST_LAST) ? '0 : wr_ptr_r + hist_addr_t'(1);
  assign fill_nxt    = (fill_r == FILL_FULL) ? fill_r : fill_r + fill_t'(1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= item;
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (cmd.exec && (item_r.command == CMD_COEF) && (int'(item_r.coef_index) < COEF_DEPTH)) begin
      coef_mem[item_r.coef_index] <= item_r.coef_value;
    end
    if (cmd.issue) begin
      coef_q_r <= coef_mem[coef_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && filter_item) begin
      hist_mem[wr_ptr_nxt] <= item_r.sample_in;
    end
    if (cmd.issue) begin
      hist_q_r <= hist_mem[rd_ptr_r];
    end
  end

  // Item state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      phase_cnt_r <= '0;
      held_r      <= '0;
      fresh_r     <= 1'b0;
    end else begin
      if (cmd.exec) begin
        fresh_r <= filter_item && ph.fired;
        if (filter_item) begin
          wr_ptr_r    <= wr_ptr_nxt;
          fill_r      <= fill_nxt;
          phase_cnt_r <= ph.counter;
        end else if (item_r.command == CMD_SAMPLE) begin
          held_r <= item_r.sample_in;
        end
      end
      if (cmd.round) begin
        held_r <= rounded;
      end
    end
  end

  // Tap walk: newest history entry first, coefficients stride by the phase count.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_ptr_r    <= wr_ptr_nxt;
      coef_addr_r <= coef_idx_t'(ph.last);
      left_r      <= fill_nxt;
    end else if (cmd.issue) begin
      rd_ptr_r    <= (rd_ptr_r == '0) ? HIST_LAST : rd_ptr_r - hist_addr_t'(1);
      coef_addr_r <= coef_addr_r + COEF_STRIDE;
      left_r      <= (left_r == '0) ? left_r : left_r - fill_t'(1);
    end
    if (cmd.issue) begin
      ok1_r <= (left_r != '0);
    end
  end

  // MAC pipeline
  assign coef_ext = prod_t'(coef_q_r);
  assign hist_ext = prod_t'(hist_q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= ok1_r ? coef_ext * hist_ext : '0;
    end
    if (cmd.exec) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + acc_t'(prod_r);
    end
  end

  // Round half up, then saturate
  assign biased = bias_t'(acc_r) + bias_t'(ROUND_HALF);
  assign quot   = biased >>> FRAC_BITS;

  always_comb begin
    if (quot > bias_t'(SAMPLE_MAX)) begin
      rounded = sample_t'(SAMPLE_MAX);
    end else if (quot < bias_t'(SAMPLE_MIN)) begin
      rounded = sample_t'(SAMPLE_MIN);
    end else begin
      rounded = quot[SAMPLE_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample_r <= held_r;
      out_fresh_r  <= fresh_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign sample_out = out_sample_r;
  assign fresh      = out_fresh_r;

  assign stat.mac_needed = filter_item && ph.fired;
  assign stat.pipe_busy  = v1_r || v2_r;
  assign stat.out_busy   = out_valid_r && !out_ready;

endmodule

[sv/polyphase_rational_resampler_unit.sv]
// Top level of the polyphase rational resampler: register block, controller and datapath.
// Depends on prr_pkg, prr_if, prr_cfg, prr_ctrl and prr_dp.
//
//   Channel  Direction  Handshake            Carries
//   in_      sink       valid/ready          command, sample_in, coef_index, coef_value
//   out_     source     valid/ready          sample_out, fresh
//   cfg_     slave      psel/penable/pready  decimation (0x0), passthrough (0x4)
//
// A coefficient write, a passthrough sample or an audio sample that fires no phase
// passes from transfer to result through the capture, execute and result states. An
// audio sample that fires a phase also runs one multiply-accumulate per tap over 257 taps
// through a single shared MAC, fed by one read port on each of the history and
// coefficient memories, then a pipeline drain and a rounding step.
// rst_n is synchronous and active low; the history reads as zero after reset by way of
// a fill count, so no clearing pass is needed. The coefficient store is not cleared.
// A new item is taken while the previous result still waits on out_; the block then
// holds the next result internally until the output register is free.
module polyphase_rational_resampler_unit (
  input  logic               clk,
  input  logic               rst_n,
  prr_in_if.sink             in_,
  prr_out_if.source          out_,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  prr_pkg::apb_addr_t cfg_paddr,
  input  prr_pkg::apb_data_t cfg_pwdata,
  output prr_pkg::apb_data_t cfg_prdata,
  output logic               cfg_pready
);
  import prr_pkg::*;

  cfg_t      cfg;
  item_t     item;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  // The incoming payload is gathered into one word; the datapath latches it on transfer.
  assign item.command    = in_.command;
  assign item.sample_in  = in_.sample_in;
  assign item.coef_index = in_.coef_index;
  assign item.coef_value = in_.coef_value;
  assign in_.ready       = in_ready;

  prr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // The controller only sequences and counts taps; the arithmetic and sample storage sit in the datapath.
  prr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  prr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item       (item),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_.valid),
    .out_ready  (out_.ready),
    .sample_out (out_.sample_out),
    .fresh      (out_.fresh)
  );

endmodule

[sv/prr_chk.sv]
// Port-level checker for the resampler, attached to the top level by a bind.
// Depends on nothing beyond the top level's port names.
module prr_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // Reset empties the output register.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A result waiting on a stalled sink is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // One item at a time: the input closes right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready straight after a transfer");

  // A result never appears in the cycle right after an input transfer.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared too early");

endmodule

bind polyphase_rational_resampler_unit prr_chk u_prr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_.valid),
  .in_ready  (in_.ready),
  .out_valid (out_.valid),
  .out_ready (out_.ready)
);
